// ----- rtl/core/lci_pkg.sv -----
// ----------------------------------------------------------------------------
// lci_pkg
// Shared types and codes for the line command interpreter.
// ----------------------------------------------------------------------------
package lci_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned StW   = 4;
    localparam int unsigned MsgW  = 3;
    localparam int unsigned CmdW  = 2;
    localparam int unsigned AddrW = 3;
    localparam int unsigned DataW = 32;

    localparam logic [ByteW-1:0] IDLE_TICKS_RESET = 8'd30;

    localparam logic [ByteW-1:0] B_IAC  = 8'd255;
    localparam logic [ByteW-1:0] B_DONT = 8'd254;
    localparam logic [ByteW-1:0] B_DO   = 8'd253;
    localparam logic [ByteW-1:0] B_WONT = 8'd252;
    localparam logic [ByteW-1:0] B_WILL = 8'd251;
    localparam logic [ByteW-1:0] B_SP   = 8'h20;
    localparam logic [ByteW-1:0] B_TAB  = 8'h09;
    localparam logic [ByteW-1:0] B_CR   = 8'h0D;
    localparam logic [ByteW-1:0] B_LF   = 8'h0A;
    localparam logic [ByteW-1:0] B_H    = 8'h68;
    localparam logic [ByteW-1:0] B_QM   = 8'h3F;
    localparam logic [ByteW-1:0] B_GU   = 8'h47;
    localparam logic [ByteW-1:0] B_GL   = 8'h67;
    localparam logic [ByteW-1:0] B_RU   = 8'h52;
    localparam logic [ByteW-1:0] B_RL   = 8'h72;
    localparam logic [ByteW-1:0] B_T    = 8'h74;
    localparam logic [ByteW-1:0] B_X    = 8'h78;

    localparam logic [CmdW-1:0] CMD_OPEN  = 2'd0;
    localparam logic [CmdW-1:0] CMD_BYTE  = 2'd1;
    localparam logic [CmdW-1:0] CMD_TICK  = 2'd2;
    localparam logic [CmdW-1:0] CMD_CLOSE = 2'd3;

    localparam logic [MsgW-1:0] MSG_NONE    = 3'd0;
    localparam logic [MsgW-1:0] MSG_INVITE  = 3'd1;
    localparam logic [MsgW-1:0] MSG_HELP    = 3'd2;
    localparam logic [MsgW-1:0] MSG_PROMPT  = 3'd3;
    localparam logic [MsgW-1:0] MSG_ERROR   = 3'd4;
    localparam logic [MsgW-1:0] MSG_TIMEOUT = 3'd5;
    localparam logic [MsgW-1:0] MSG_TIME    = 3'd6;

    localparam logic [StW-1:0] PS_INIT   = 4'd0;
    localparam logic [StW-1:0] PS_IAC    = 4'd1;
    localparam logic [StW-1:0] PS_OPTION = 4'd2;
    localparam logic [StW-1:0] PS_HELP   = 4'd3;
    localparam logic [StW-1:0] PS_GON    = 4'd4;
    localparam logic [StW-1:0] PS_GOFF   = 4'd5;
    localparam logic [StW-1:0] PS_RON    = 4'd6;
    localparam logic [StW-1:0] PS_ROFF   = 4'd7;
    localparam logic [StW-1:0] PS_TIME   = 4'd8;
    localparam logic [StW-1:0] PS_EXIT   = 4'd9;
    localparam logic [StW-1:0] PS_ERROR  = 4'd10;

    localparam logic [AddrW-3:0] REG_IDLE_TICKS = 1'd0;

    typedef struct packed {
        logic [CmdW-1:0]  command;
        logic [ByteW-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [MsgW-1:0] message;
        logic            close_session;
        logic            green_on;
        logic            red_on;
    } t_out_item;

endpackage

// ----- rtl/core/lci_cfg.sv -----
// ----------------------------------------------------------------------------
// lci_cfg
// APB register file holding the idle tick reload value.
// ----------------------------------------------------------------------------
module lci_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [lci_pkg::AddrW-1:0] paddr,
    input  logic [lci_pkg::DataW-1:0] pwdata,
    output logic [lci_pkg::DataW-1:0] prdata,
    output logic                      pready,
    output logic [lci_pkg::ByteW-1:0] o_idle_ticks
);
    import lci_pkg::*;

    logic [ByteW-1:0] r_idle_ticks;
    logic [ByteW-1:0] n_idle_ticks;
    logic             reg_sel;

    assign reg_sel = (paddr[AddrW-1:2] == REG_IDLE_TICKS);
    assign pready  = 1'b1;

    always_comb begin
        n_idle_ticks = r_idle_ticks;
        if (psel && penable && pwrite && reg_sel) begin
            n_idle_ticks = pwdata[ByteW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_ticks <= IDLE_TICKS_RESET;
        end else begin
            r_idle_ticks <= n_idle_ticks;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel) begin
            prdata = {{(DataW-ByteW){1'b0}}, r_idle_ticks};
        end
    end

    assign o_idle_ticks = r_idle_ticks;

endmodule

// ----- rtl/core/lci_parser.sv -----
// ----------------------------------------------------------------------------
// lci_parser
// Session state and per-byte command parser; one transition per item.
// ----------------------------------------------------------------------------
module lci_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  lci_pkg::t_in_item         i_item,
    input  logic [lci_pkg::ByteW-1:0] i_idle_ticks,
    output lci_pkg::t_out_item        o_result
);
    import lci_pkg::*;

    logic [StW-1:0]   r_state;
    logic [StW-1:0]   n_state;
    logic [ByteW-1:0] r_idle_cnt;
    logic [ByteW-1:0] n_idle_cnt;
    logic             r_active;
    logic             n_active;
    logic             r_green;
    logic             n_green;
    logic             r_red;
    logic             n_red;
    logic [MsgW-1:0]  msg;
    logic             closing;
    logic             blank;
    logic             newline;
    logic             negot;
    logic [ByteW-1:0] b;

    assign b       = i_item.data_byte;
    assign blank   = (b == B_SP) || (b == B_TAB) || (b == B_CR);
    assign newline = (b == B_LF);
    assign negot   = (b == B_DONT) || (b == B_DO) || (b == B_WONT) || (b == B_WILL);

    always_comb begin
        n_state    = r_state;
        n_idle_cnt = r_idle_cnt;
        n_active   = r_active;
        n_green    = r_green;
        n_red      = r_red;
        msg        = MSG_NONE;
        closing    = 1'b0;
        if (i_item.command == CMD_OPEN) begin
            n_active   = 1'b1;
            n_state    = PS_INIT;
            n_idle_cnt = i_idle_ticks;
            msg        = MSG_INVITE;
        end else if (r_active) begin
            unique case (i_item.command)
                CMD_BYTE: begin
                    n_idle_cnt = i_idle_ticks;
                    unique case (r_state) inside
                        PS_INIT: begin
                            if (b == B_IAC) begin
                                n_state = PS_IAC;
                            end else if (blank) begin
                                n_state = PS_INIT;
                            end else if (newline) begin
                                msg = MSG_PROMPT;
                            end else begin
                                case (b) inside
                                    B_H, B_QM: n_state = PS_HELP;
                                    B_GU:      n_state = PS_GON;
                                    B_GL:      n_state = PS_GOFF;
                                    B_RU:      n_state = PS_RON;
                                    B_RL:      n_state = PS_ROFF;
                                    B_T:       n_state = PS_TIME;
                                    B_X:       n_state = PS_EXIT;
                                    default:   n_state = PS_ERROR;
                                endcase
                            end
                        end
                        PS_IAC: begin
                            n_state = negot ? PS_OPTION : PS_ERROR;
                        end
                        PS_OPTION: begin
                            n_state = PS_INIT;
                        end
                        PS_HELP, PS_GON, PS_GOFF, PS_RON, PS_ROFF, PS_TIME, PS_EXIT: begin
                            if (newline) begin
                                n_state = PS_INIT;
                                case (r_state)
                                    PS_HELP: msg = MSG_HELP;
                                    PS_GON: begin
                                        n_green = 1'b1;
                                        msg     = MSG_PROMPT;
                                    end
                                    PS_GOFF: begin
                                        n_green = 1'b0;
                                        msg     = MSG_PROMPT;
                                    end
                                    PS_RON: begin
                                        n_red = 1'b1;
                                        msg   = MSG_PROMPT;
                                    end
                                    PS_ROFF: begin
                                        n_red = 1'b0;
                                        msg   = MSG_PROMPT;
                                    end
                                    PS_TIME: msg = MSG_TIME;
                                    default: closing = 1'b1;
                                endcase
                            end else if (!blank) begin
                                n_state = PS_ERROR;
                            end
                        end
                        default: begin
                            if (newline) begin
                                n_state = PS_INIT;
                                msg     = MSG_ERROR;
                            end else begin
                                n_state = PS_ERROR;
                            end
                        end
                    endcase
                end
                CMD_TICK: begin
                    if (r_idle_cnt <= 8'd1) begin
                        msg     = MSG_TIMEOUT;
                        closing = 1'b1;
                    end else begin
                        n_idle_cnt = r_idle_cnt - 8'd1;
                    end
                end
                default: begin
                    closing = 1'b1;
                end
            endcase
            if (closing) begin
                n_active   = 1'b0;
                n_state    = PS_INIT;
                n_idle_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= PS_INIT;
            r_idle_cnt <= '0;
            r_active   <= 1'b0;
            r_green    <= 1'b0;
            r_red      <= 1'b0;
        end else if (i_accept) begin
            r_state    <= n_state;
            r_idle_cnt <= n_idle_cnt;
            r_active   <= n_active;
            r_green    <= n_green;
            r_red      <= n_red;
        end
    end

    always_comb begin
        o_result.message       = msg;
        o_result.close_session = closing;
        o_result.green_on      = n_green;
        o_result.red_on        = n_red;
    end

endmodule

// ----- rtl/core/lci_outbuf.sv -----
// ----------------------------------------------------------------------------
// lci_outbuf
// Result register with a skid stage; decouples input from output stall.
// ----------------------------------------------------------------------------
module lci_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lci_pkg::t_out_item i_result,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output lci_pkg::t_out_item o_data
);
    import lci_pkg::*;

    logic      r_out_vld;
    logic      r_skid_vld;
    t_out_item r_out;
    t_out_item r_skid;
    logic      pop;

    assign pop = r_out_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_vld && !pop) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_vld && !pop) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

    assign o_full  = r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// ----- rtl/core/line_command_interpreter_top.sv -----
// ----------------------------------------------------------------------------
// line_command_interpreter_top
// Session command-line interpreter: parser, LED levels and idle timeout.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries session events:
// open, received byte, poll tick and peer close. Each event yields exactly one
// result on the output channel (o_out_valid / i_out_stall / o_out_data) with a
// message code, a close flag and the current LED levels.
// The result is registered in the result buffer before it is presented. One event
// per cycle is accepted while o_in_stall is low: the parser makes a single state
// transition per event and the result register has a skid stage behind it.
// When the receiver stalls, up to two results are held; o_in_stall rises only
// when both are occupied and drops the cycle after the output transfers.
// Reset closes any session, clears the parser and LEDs, drains the result
// buffer and loads the idle tick register with 30.
// The idle tick register sits at APB address 0; write it only while idle.
// ----------------------------------------------------------------------------
module line_command_interpreter_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  lci_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output lci_pkg::t_out_item        o_out_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [lci_pkg::AddrW-1:0] paddr,
    input  logic [lci_pkg::DataW-1:0] pwdata,
    output logic [lci_pkg::DataW-1:0] prdata,
    output logic                      pready
);
    import lci_pkg::*;

    logic [ByteW-1:0] idle_ticks;
    logic             accept;
    logic             buf_full;
    t_out_item        result;

    assign accept     = i_in_valid && !buf_full;
    assign o_in_stall = buf_full;

    lci_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_idle_ticks (idle_ticks)
    );

    lci_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (i_in_data),
        .i_idle_ticks (idle_ticks),
        .o_result     (result)
    );

    lci_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_result (result),
        .o_full   (buf_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_data   (o_out_data)
    );

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no pending result");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_stall && !i_out_stall) |=> !o_in_stall)
        else $error("skid stage did not drain after output transfer");

    a_close_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.close_session) |->
        (o_out_data.message == MSG_NONE || o_out_data.message == MSG_TIMEOUT))
        else $error("session close carries an unexpected message");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted event produced no result");

endmodule

// ----- verif/line_command_interpreter_top_tb.sv -----
// ----------------------------------------------------------------------------
// line_command_interpreter_top_tb
// Drives session events (open, byte, tick, peer close) into the interpreter and
// predicts each reply: message code, close flag and LED levels. Covers a
// directed pass of command lines, telnet option sequences, error lines and
// timeouts, then random sessions under several idle-tick settings, with
// sender gaps, receiver stalls, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module line_command_interpreter_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lci_pkg::*;

    localparam int IDLE_NONE   = 0;
    localparam int IDLE_SEND   = 1;
    localparam int IDLE_RECV   = 2;
    localparam int IDLE_BOTH   = 3;
    localparam int GAP_PCT     = 59;
    localparam int BOTH_PCT    = 22;
    localparam int HOLD_CYCLES = 48;
    localparam int STUCK_LIMIT = 2000;
    localparam int PHASE_ITEMS = 430;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrW-1:0]     paddr = '0;
    logic [DataW-1:0]     pwdata = '0;
    logic [DataW-1:0]     prdata;
    logic                 pready;

    t_in_item             event_q[$];
    t_out_item            reply_q[$];
    int                   errors = 0;
    int                   items_queued = 0;
    int                   idle_mode = IDLE_NONE;
    int                   hold_requests = 0;
    int                   hold_served = 0;
    int                   hold_left = 0;
    int                   stuck_cycles = 0;

    logic                 session_open = 1'b0;
    logic [StW-1:0]       parse_state = PS_INIT;
    logic [ByteW-1:0]     idle_left = '0;
    logic [ByteW-1:0]     idle_reload = IDLE_TICKS_RESET;
    logic                 green_lvl = 1'b0;
    logic                 red_lvl = 1'b0;

    line_command_interpreter_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic is_blank(logic [ByteW-1:0] b);
        return b inside {B_SP, B_TAB, B_CR};
    endfunction

    function automatic t_out_item interpret_event(t_in_item ev);
        t_out_item        r;
        logic [MsgW-1:0]  msg;
        logic             closing;
        logic [StW-1:0]   ps;
        logic [ByteW-1:0] b;
        msg = MSG_NONE;
        closing = 1'b0;
        b = ev.data_byte;
        ps = parse_state;
        if (ev.command == CMD_OPEN) begin
            session_open = 1'b1;
            parse_state = PS_INIT;
            idle_left = idle_reload;
            msg = MSG_INVITE;
        end else if (session_open) begin
            if (ev.command == CMD_BYTE) begin
                idle_left = idle_reload;
                if (ps == PS_INIT) begin
                    if (b == B_IAC) begin
                        parse_state = PS_IAC;
                    end else if (b == B_LF) begin
                        msg = MSG_PROMPT;
                    end else if (!is_blank(b)) begin
                        case (b)
                            B_H, B_QM: parse_state = PS_HELP;
                            B_GU:      parse_state = PS_GON;
                            B_GL:      parse_state = PS_GOFF;
                            B_RU:      parse_state = PS_RON;
                            B_RL:      parse_state = PS_ROFF;
                            B_T:       parse_state = PS_TIME;
                            B_X:       parse_state = PS_EXIT;
                            default:   parse_state = PS_ERROR;
                        endcase
                    end
                end else if (ps == PS_IAC) begin
                    parse_state = (b inside {B_DONT, B_DO, B_WONT, B_WILL}) ? PS_OPTION
                                                                            : PS_ERROR;
                end else if (ps == PS_OPTION) begin
                    parse_state = PS_INIT;
                end else if (ps >= PS_HELP && ps <= PS_EXIT) begin
                    if (b != B_LF && !is_blank(b)) begin
                        parse_state = PS_ERROR;
                    end else if (b == B_LF) begin
                        parse_state = PS_INIT;
                        case (ps)
                            PS_HELP: msg = MSG_HELP;
                            PS_GON: begin
                                green_lvl = 1'b1;
                                msg = MSG_PROMPT;
                            end
                            PS_GOFF: begin
                                green_lvl = 1'b0;
                                msg = MSG_PROMPT;
                            end
                            PS_RON: begin
                                red_lvl = 1'b1;
                                msg = MSG_PROMPT;
                            end
                            PS_ROFF: begin
                                red_lvl = 1'b0;
                                msg = MSG_PROMPT;
                            end
                            PS_TIME: msg = MSG_TIME;
                            default: closing = 1'b1;
                        endcase
                    end
                end else if (b == B_LF) begin
                    parse_state = PS_INIT;
                    msg = MSG_ERROR;
                end else begin
                    parse_state = PS_ERROR;
                end
            end else if (ev.command == CMD_TICK) begin
                if (idle_left <= 1) begin
                    msg = MSG_TIMEOUT;
                    closing = 1'b1;
                end else begin
                    idle_left = idle_left - 1'b1;
                end
            end else begin
                closing = 1'b1;
            end
            if (closing) begin
                session_open = 1'b0;
                parse_state = PS_INIT;
                idle_left = '0;
            end
        end
        r.message = msg;
        r.close_session = closing;
        r.green_on = green_lvl;
        r.red_on = red_lvl;
        return r;
    endfunction

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0d got %0d", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        logic gap;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                reply_q.push_back(interpret_event(in_data));
            end
            if (!in_valid || !in_stall) begin
                gap = (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
                      $urandom_range(0, 99) < (idle_mode == IDLE_BOTH ? BOTH_PCT : GAP_PCT);
                if (event_q.size() != 0 && !gap) begin
                    in_data <= event_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (reply_q.size() == 0) begin
                    $display("%0t ns: unexpected result %p", $time, out_data);
                    errors++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("message", 8'(want.message), 8'(out_data.message));
                    check_field("close_session", 8'(want.close_session),
                                8'(out_data.close_session));
                    check_field("green_on", 8'(want.green_on), 8'(out_data.green_on));
                    check_field("red_on", 8'(want.red_on), 8'(out_data.red_on));
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else if (hold_served != hold_requests) begin
                hold_served <= hold_served + 1;
                hold_left <= HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) &&
                    $urandom_range(0, 99) < (idle_mode == IDLE_BOTH ? BOTH_PCT : GAP_PCT);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable && pready) ||
            !(in_valid || psel || event_q.size() != 0 || reply_q.size() != 0)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, stuck_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic push_event(logic [CmdW-1:0] cmd, logic [ByteW-1:0] b);
        t_in_item ev;
        ev.command = cmd;
        ev.data_byte = b;
        event_q.push_back(ev);
        items_queued++;
    endtask

    task automatic push_byte(logic [ByteW-1:0] b);
        push_event(CMD_BYTE, b);
    endtask

    function automatic logic [ByteW-1:0] blank_byte();
        case ($urandom_range(0, 2))
            0:       return B_SP;
            1:       return B_TAB;
            default: return B_CR;
        endcase
    endfunction

    task automatic push_blanks();
        repeat ($urandom_range(0, 2)) push_byte(blank_byte());
    endtask

    task automatic wait_drained();
        while (event_q.size() != 0 || in_valid || reply_q.size() != 0) @(posedge clk);
    endtask

    task automatic program_idle(logic [ByteW-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_IDLE_TICKS, 2'b00};
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        idle_reload = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        check_field("idle_ticks readback", value, prdata[7:0]);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic gen_session();
        logic [ByteW-1:0] letters[7] = '{B_H, B_QM, B_GU, B_GL, B_RU, B_RL, B_T};
        logic [ByteW-1:0] verbs[4] = '{B_DO, B_DONT, B_WILL, B_WONT};
        int kind;
        push_event(CMD_OPEN, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 10)) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                push_blanks();
                push_byte(letters[3'($urandom_range(0, 6))]);
                push_blanks();
                if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)));
                push_byte(B_LF);
            end else if (kind < 62) begin
                push_byte(B_IAC);
                push_byte($urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 255))
                                                    : verbs[2'($urandom_range(0, 3))]);
                push_byte(8'($urandom_range(0, 255)));
            end else if (kind < 72) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
                push_byte(B_LF);
            end else if (kind < 88) begin
                repeat ($urandom_range(1, 3))
                    push_event(CMD_TICK, 8'($urandom_range(0, 255)));
            end else if (kind < 92) begin
                push_event(CMD_OPEN, 8'($urandom_range(0, 255)));
            end else begin
                push_byte($urandom_range(0, 1) ? B_LF : blank_byte());
            end
        end
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            push_blanks();
            push_byte(B_X);
            push_blanks();
            push_byte(B_LF);
        end else if (kind < 7 || (kind < 9 && idle_reload > 40)) begin
            push_event(CMD_CLOSE, 8'($urandom_range(0, 255)));
        end else if (kind < 9) begin
            repeat (idle_reload + 1) push_event(CMD_TICK, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3))
                push_event(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic gen_traffic(int count);
        int start;
        start = items_queued;
        while (items_queued - start < count) begin
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 6))
                    push_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                gen_session();
            end
        end
    endtask

    initial begin
        int               modes[4] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
        logic [ByteW-1:0] settings[4];
        settings = '{8'd255, 8'd1, 8'($urandom_range(2, 40)), 8'($urandom_range(2, 40))};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_event(CMD_CLOSE, B_IAC);
        push_event(CMD_TICK, 8'h00);
        push_byte(B_H);
        push_event(CMD_OPEN, 8'h00);
        push_byte(B_H);
        push_byte(B_SP);
        push_byte(B_TAB);
        push_byte(B_CR);
        push_byte(B_LF);
        push_byte(B_GU);
        push_byte(B_LF);
        push_byte(B_RU);
        push_byte(B_LF);
        push_byte(B_T);
        push_byte(B_LF);
        push_byte("$");
        push_byte(B_LF);
        push_byte(B_IAC);
        push_byte(B_DO);
        push_byte(8'h01);
        push_byte(B_IAC);
        push_byte(8'h00);
        push_byte(B_LF);
        push_byte(B_GL);
        push_byte(B_LF);
        push_byte(B_RL);
        push_byte(B_LF);
        push_event(CMD_OPEN, 8'hFF);
        push_event(CMD_TICK, 8'hFF);
        push_byte(B_X);
        push_byte(B_LF);
        push_event(CMD_OPEN, 8'h55);
        push_event(CMD_CLOSE, 8'hAA);
        wait_drained();
        repeat (4) @(posedge clk);
        program_idle(8'd1);
        push_event(CMD_OPEN, 8'h00);
        push_event(CMD_TICK, 8'h00);
        push_event(CMD_OPEN, 8'h00);
        push_byte(B_H);
        push_event(CMD_TICK, 8'h00);
        wait_drained();
        repeat (4) @(posedge clk);
        program_idle(8'd0);
        push_event(CMD_OPEN, 8'h00);
        push_event(CMD_TICK, 8'h00);

        for (int p = 0; p < 4; p++) begin
            wait_drained();
            repeat (4) @(posedge clk);
            program_idle(settings[p]);
            idle_mode = modes[p];
            gen_traffic(PHASE_ITEMS / 2);
            if (p == 0) hold_requests++;
            wait_drained();
            gen_traffic(PHASE_ITEMS / 2);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lci_pkg.sv
rtl/core/lci_cfg.sv
rtl/core/lci_parser.sv
rtl/core/lci_outbuf.sv
rtl/core/line_command_interpreter_top.sv
verif/line_command_interpreter_top_tb.sv
